// ===== design/aaeu_pkg.sv =====
`default_nettype none

package aaeu_pkg;

    localparam int WORD_BITS  = 32;
    localparam int SHAMT_W    = $clog2(WORD_BITS);
    localparam int REG_COUNT  = 15;
    localparam int REG_ADDR_W = 4;

    localparam logic [REG_ADDR_W-1:0] PC_REG = 4'd15;

    // condition codes
    localparam logic [3:0] COND_EQ = 4'd0;
    localparam logic [3:0] COND_NE = 4'd1;
    localparam logic [3:0] COND_GE = 4'd10;
    localparam logic [3:0] COND_LT = 4'd11;
    localparam logic [3:0] COND_GT = 4'd12;
    localparam logic [3:0] COND_LE = 4'd13;
    localparam logic [3:0] COND_AL = 4'd14;

    // data-processing opcodes
    localparam logic [3:0] OP_AND = 4'd0;
    localparam logic [3:0] OP_EOR = 4'd1;
    localparam logic [3:0] OP_SUB = 4'd2;
    localparam logic [3:0] OP_RSB = 4'd3;
    localparam logic [3:0] OP_ADD = 4'd4;
    localparam logic [3:0] OP_ADC = 4'd5;
    localparam logic [3:0] OP_SBC = 4'd6;
    localparam logic [3:0] OP_RSC = 4'd7;
    localparam logic [3:0] OP_TST = 4'd8;
    localparam logic [3:0] OP_TEQ = 4'd9;
    localparam logic [3:0] OP_CMP = 4'd10;
    localparam logic [3:0] OP_CMN = 4'd11;
    localparam logic [3:0] OP_ORR = 4'd12;
    localparam logic [3:0] OP_MOV = 4'd13;
    localparam logic [3:0] OP_BIC = 4'd14;
    localparam logic [3:0] OP_MVN = 4'd15;

    // shift types
    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    typedef struct packed {
        logic [WORD_BITS-1:0] instr;
        logic [WORD_BITS-1:0] pc_value;
    } in_t;

    typedef struct packed {
        logic                  executed;
        logic                  dest_written;
        logic [REG_ADDR_W-1:0] dest_reg;
        logic [WORD_BITS-1:0]  write_value;
        logic [3:0]            flags_nzcv;
    } out_t;

    function automatic logic [WORD_BITS-1:0] ror_word(
        input logic [WORD_BITS-1:0] x,
        input logic [SHAMT_W-1:0]   amt
    );
        logic [2*WORD_BITS-1:0] dbl;
        dbl = {x, x} >> amt;
        return dbl[WORD_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/aaeu_ram.sv =====
`default_nettype none

// 1 write port, 2 read ports, registered read data
module aaeu_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr_a,
    input  wire logic [ADDR_W-1:0] rd_addr_b,
    output logic      [DATA_W-1:0] rd_data_a,
    output logic      [DATA_W-1:0] rd_data_b
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

`default_nettype wire

// ===== design/aaeu_shifter.sv =====
`default_nettype none

// operand 2: rotated immediate or shifted Rm, with shifter carry out
module aaeu_shifter (
    input  wire logic [aaeu_pkg::WORD_BITS-1:0] instr,
    input  wire logic [aaeu_pkg::WORD_BITS-1:0] rm,
    input  wire logic [7:0]                     rs_amt,
    input  wire logic                           cin,
    output logic      [aaeu_pkg::WORD_BITS-1:0] op2,
    output logic                                carry
);

    localparam int W = aaeu_pkg::WORD_BITS;
    localparam logic [7:0] FULL_AMT = 8'(W);

    logic [1:0]                     shift_type;
    logic [7:0]                     nz_amt;
    logic                           nz_big;
    logic [aaeu_pkg::SHAMT_W:0]     nz_amt_c;
    logic [W:0]                     lsl_full;
    logic [W:0]                     lsr_full;
    logic [W:0]                     asr_full;
    logic [W-1:0]                   ror_val;
    logic [W-1:0]                   nz_val;
    logic                           nz_c;
    logic [aaeu_pkg::SHAMT_W-1:0]   rot;
    logic [W-1:0]                   imm_val;

    always_comb
    begin
        shift_type = instr[6:5];
        // immediate amount of zero encodes 32 for LSR/ASR
        if (instr[4])
        begin
            nz_amt = rs_amt;
        end
        else if (instr[11:7] == 5'd0)
        begin
            nz_amt = FULL_AMT;
        end
        else
        begin
            nz_amt = {3'b000, instr[11:7]};
        end

        nz_big   = nz_amt > FULL_AMT;
        nz_amt_c = nz_big ? FULL_AMT[aaeu_pkg::SHAMT_W:0] : nz_amt[aaeu_pkg::SHAMT_W:0];
        lsl_full = {1'b0, rm} << nz_amt_c;
        lsr_full = {rm, 1'b0} >> nz_amt_c;
        asr_full = $signed({rm, 1'b0}) >>> nz_amt_c;
        ror_val  = aaeu_pkg::ror_word(rm, nz_amt[aaeu_pkg::SHAMT_W-1:0]);

        case (shift_type)
            aaeu_pkg::SH_LSL:
            begin
                nz_val = nz_big ? '0 : lsl_full[W-1:0];
                nz_c   = nz_big ? 1'b0 : lsl_full[W];
            end
            aaeu_pkg::SH_LSR:
            begin
                nz_val = nz_big ? '0 : lsr_full[W:1];
                nz_c   = nz_big ? 1'b0 : lsr_full[0];
            end
            aaeu_pkg::SH_ASR:
            begin
                nz_val = asr_full[W:1];
                nz_c   = asr_full[0];
            end
            default:
            begin
                nz_val = ror_val;
                nz_c   = ror_val[W-1];
            end
        endcase

        rot     = {instr[11:8], 1'b0};
        imm_val = aaeu_pkg::ror_word({{(W-8){1'b0}}, instr[7:0]}, rot);

        if (instr[25])
        begin
            op2   = imm_val;
            carry = (rot == '0) ? cin : imm_val[W-1];
        end
        else if (instr[4] && rs_amt == 8'd0)
        begin
            op2   = rm;
            carry = cin;
        end
        else if (!instr[4] && instr[11:7] == 5'd0 && shift_type == aaeu_pkg::SH_LSL)
        begin
            op2   = rm;
            carry = cin;
        end
        else if (!instr[4] && instr[11:7] == 5'd0 && shift_type == aaeu_pkg::SH_ROR)
        begin
            // RRX
            op2   = {cin, rm[W-1:1]};
            carry = rm[0];
        end
        else
        begin
            op2   = nz_val;
            carry = nz_c;
        end
    end

endmodule

`default_nettype wire

// ===== design/aaeu_alu.sv =====
`default_nettype none

// condition check, data-processing ALU and MUL/MLA
module aaeu_alu (
    input  wire logic [aaeu_pkg::WORD_BITS-1:0] instr,
    input  wire logic [aaeu_pkg::WORD_BITS-1:0] rn,
    input  wire logic [aaeu_pkg::WORD_BITS-1:0] op2,
    input  wire logic                           shift_c,
    input  wire logic [aaeu_pkg::WORD_BITS-1:0] rm,
    input  wire logic [aaeu_pkg::WORD_BITS-1:0] rs,
    input  wire logic [aaeu_pkg::WORD_BITS-1:0] acc,
    input  wire logic [3:0]                     flags,
    output aaeu_pkg::out_t                      res
);

    localparam int W = aaeu_pkg::WORD_BITS;

    logic           fn, fz, fc, fv;
    logic           cond_ok;
    logic           is_dp;
    logic           is_mul;
    logic           run;
    logic [3:0]     op;
    logic [W-1:0]   add_x;
    logic [W-1:0]   add_y;
    logic           add_ci;
    logic           is_logic;
    logic [W-1:0]   logic_res;
    logic [W:0]     sum;
    logic           add_v;
    logic [W-1:0]   dp_res;
    logic [2*W-1:0] prod;
    logic [W-1:0]   mul_res;

    always_comb
    begin
        {fn, fz, fc, fv} = flags;

        case (instr[31:28])
            aaeu_pkg::COND_EQ: cond_ok = fz;
            aaeu_pkg::COND_NE: cond_ok = !fz;
            aaeu_pkg::COND_GE: cond_ok = fn == fv;
            aaeu_pkg::COND_LT: cond_ok = fn != fv;
            aaeu_pkg::COND_GT: cond_ok = !fz && fn == fv;
            aaeu_pkg::COND_LE: cond_ok = fz || fn != fv;
            aaeu_pkg::COND_AL: cond_ok = 1'b1;
            default:           cond_ok = 1'b0;
        endcase

        run    = instr != '0 && cond_ok && instr[27:26] == 2'b00;
        is_dp  = instr[25] || !instr[4] || !instr[7];
        is_mul = instr[27:22] == 6'd0 && instr[7:4] == 4'b1001;
        op     = instr[24:21];

        add_x     = rn;
        add_y     = ~op2;
        add_ci    = 1'b1;
        is_logic  = 1'b1;
        logic_res = '0;
        case (op)
            aaeu_pkg::OP_AND, aaeu_pkg::OP_TST: logic_res = rn & op2;
            aaeu_pkg::OP_EOR, aaeu_pkg::OP_TEQ: logic_res = rn ^ op2;
            aaeu_pkg::OP_SUB, aaeu_pkg::OP_CMP: is_logic = 1'b0;
            aaeu_pkg::OP_RSB:
            begin
                add_x    = op2;
                add_y    = ~rn;
                is_logic = 1'b0;
            end
            aaeu_pkg::OP_ADD, aaeu_pkg::OP_CMN:
            begin
                add_y    = op2;
                add_ci   = 1'b0;
                is_logic = 1'b0;
            end
            aaeu_pkg::OP_ADC:
            begin
                add_y    = op2;
                add_ci   = fc;
                is_logic = 1'b0;
            end
            aaeu_pkg::OP_SBC:
            begin
                add_ci   = fc;
                is_logic = 1'b0;
            end
            aaeu_pkg::OP_RSC:
            begin
                add_x    = op2;
                add_y    = ~rn;
                add_ci   = fc;
                is_logic = 1'b0;
            end
            aaeu_pkg::OP_ORR: logic_res = rn | op2;
            aaeu_pkg::OP_MOV: logic_res = op2;
            aaeu_pkg::OP_BIC: logic_res = rn & ~op2;
            default:          logic_res = ~op2;
        endcase

        sum    = {1'b0, add_x} + {1'b0, add_y} + {{W{1'b0}}, add_ci};
        add_v  = ~(add_x[W-1] ^ add_y[W-1]) & (add_x[W-1] ^ sum[W-1]);
        dp_res = is_logic ? logic_res : sum[W-1:0];

        prod    = rm * rs;
        mul_res = instr[21] ? prod[W-1:0] + acc : prod[W-1:0];

        res.executed     = 1'b0;
        res.dest_written = 1'b0;
        res.dest_reg     = '0;
        res.write_value  = '0;
        res.flags_nzcv   = flags;

        if (run && is_dp)
        begin
            res.executed    = 1'b1;
            res.write_value = dp_res;
            if (!(op inside {aaeu_pkg::OP_TST, aaeu_pkg::OP_TEQ,
                             aaeu_pkg::OP_CMP, aaeu_pkg::OP_CMN}))
            begin
                res.dest_written = 1'b1;
                res.dest_reg     = instr[15:12];
            end
            if (instr[20])
            begin
                res.flags_nzcv[3] = dp_res[W-1];
                res.flags_nzcv[2] = dp_res == '0;
                res.flags_nzcv[1] = is_logic ? shift_c : sum[W];
                res.flags_nzcv[0] = is_logic ? fv : add_v;
            end
        end
        else if (run && is_mul)
        begin
            res.executed     = 1'b1;
            res.dest_written = 1'b1;
            res.dest_reg     = instr[19:16];
            res.write_value  = mul_res;
            if (instr[20])
            begin
                res.flags_nzcv[3] = mul_res[W-1];
                res.flags_nzcv[2] = mul_res == '0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/arm_alu_execute_unit_core.sv =====
`default_nettype none

// Channel   Direction  Payload            Handshake
// instr     to block   aaeu_pkg::in_t     instr_valid / instr_stall
// result    from block aaeu_pkg::out_t    result_valid / result_stall
//
// One instruction per cycle sustained while the result is not stalled. The accepting
// edge reads the register file into the execute stage, which then executes into the
// output register, where the result is shown until it is taken.
// The register file lives in two copies of a synchronous RAM with registered reads,
// giving four read ports; the entry written at the edge an instruction reads the RAM
// comes through a one-entry bypass register. Flags are held in flops.
// Reset clears the flags, the bypass and one valid bit per register (an entry
// never written reads zero); no clearing pass is needed.
// A stalled result holds the execute stage, which then stalls the instr channel.

module arm_alu_execute_unit_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           instr_valid,
    output logic                instr_stall,
    input  wire aaeu_pkg::in_t  instr_data,
    output logic                result_valid,
    input  wire logic           result_stall,
    output aaeu_pkg::out_t      result_data
);

    localparam int W  = aaeu_pkg::WORD_BITS;
    localparam int RC = aaeu_pkg::REG_COUNT;
    localparam int AW = aaeu_pkg::REG_ADDR_W;

    // control
    logic           accept;
    logic           advance;
    logic           ex_valid_reg, ex_valid_next;
    logic           result_valid_reg, result_valid_next;

    // execute-stage transaction
    aaeu_pkg::in_t  ex_data_reg;
    aaeu_pkg::out_t result_data_reg;

    // architectural state
    logic [3:0]     flags_reg, flags_next;
    logic [RC-1:0]  regs_valid_reg, regs_valid_next;
    logic [RC:0]    valid_ext;

    // bypass of the most recent register write
    logic           byp_valid_reg, byp_valid_next;
    logic [AW-1:0]  byp_idx_reg;
    logic [W-1:0]   byp_data_reg;

    // RAM read data (copy A: Rn, Rm; copy B: Rs, MLA accumulate)
    logic [W-1:0]   raw_rn, raw_rm, raw_rs, raw_acc;
    logic [W-1:0]   op_rn, op_rm, op_rs, op_acc;

    logic [W-1:0]   op2;
    logic           shift_c;
    aaeu_pkg::out_t ex_res;

    logic           wb_en;
    logic [AW-1:0]  wb_addr;

    function automatic logic [W-1:0] pick_operand(
        input logic [AW-1:0] idx,
        input logic [W-1:0]  raw,
        input logic [W-1:0]  pc,
        input logic          byp_valid,
        input logic [AW-1:0] byp_idx,
        input logic [W-1:0]  byp_data,
        input logic [RC:0]   valid_bits
    );
        logic [W-1:0] val;
        if (idx == aaeu_pkg::PC_REG)
        begin
            val = pc;
        end
        else if (byp_valid && byp_idx == idx)
        begin
            val = byp_data;
        end
        else if (valid_bits[idx])
        begin
            val = raw;
        end
        else
        begin
            val = '0;
        end
        return val;
    endfunction

    // handshake
    assign advance      = ex_valid_reg && (!result_valid_reg || !result_stall);
    assign instr_stall  = ex_valid_reg && !advance;
    assign accept       = instr_valid && !instr_stall;
    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

    always_comb
    begin
        if (accept)
        begin
            ex_valid_next = 1'b1;
        end
        else if (advance)
        begin
            ex_valid_next = 1'b0;
        end
        else
        begin
            ex_valid_next = ex_valid_reg;
        end

        if (advance)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    aaeu_ram #(
        .DATA_W (W),
        .DEPTH  (RC),
        .ADDR_W (AW)
    ) u_rf_a (
        .clk       (clk),
        .wr_en     (wb_en),
        .wr_addr   (wb_addr),
        .wr_data   (ex_res.write_value),
        .rd_en     (accept),
        .rd_addr_a (instr_data.instr[19:16]),
        .rd_addr_b (instr_data.instr[3:0]),
        .rd_data_a (raw_rn),
        .rd_data_b (raw_rm)
    );

    aaeu_ram #(
        .DATA_W (W),
        .DEPTH  (RC),
        .ADDR_W (AW)
    ) u_rf_b (
        .clk       (clk),
        .wr_en     (wb_en),
        .wr_addr   (wb_addr),
        .wr_data   (ex_res.write_value),
        .rd_en     (accept),
        .rd_addr_a (instr_data.instr[11:8]),
        .rd_addr_b (instr_data.instr[15:12]),
        .rd_data_a (raw_rs),
        .rd_data_b (raw_acc)
    );

    // operand resolve: PC, then bypass, then RAM (zero if never written)
    assign valid_ext = {1'b0, regs_valid_reg};

    always_comb
    begin
        op_rn  = pick_operand(ex_data_reg.instr[19:16], raw_rn, ex_data_reg.pc_value,
                              byp_valid_reg, byp_idx_reg, byp_data_reg, valid_ext);
        op_rm  = pick_operand(ex_data_reg.instr[3:0], raw_rm, ex_data_reg.pc_value,
                              byp_valid_reg, byp_idx_reg, byp_data_reg, valid_ext);
        op_rs  = pick_operand(ex_data_reg.instr[11:8], raw_rs, ex_data_reg.pc_value,
                              byp_valid_reg, byp_idx_reg, byp_data_reg, valid_ext);
        op_acc = pick_operand(ex_data_reg.instr[15:12], raw_acc, ex_data_reg.pc_value,
                              byp_valid_reg, byp_idx_reg, byp_data_reg, valid_ext);
    end

    aaeu_shifter u_shifter (
        .instr  (ex_data_reg.instr),
        .rm     (op_rm),
        .rs_amt (op_rs[7:0]),
        .cin    (flags_reg[1]),
        .op2    (op2),
        .carry  (shift_c)
    );

    aaeu_alu u_alu (
        .instr   (ex_data_reg.instr),
        .rn      (op_rn),
        .op2     (op2),
        .shift_c (shift_c),
        .rm      (op_rm),
        .rs      (op_rs),
        .acc     (op_acc),
        .flags   (flags_reg),
        .res     (ex_res)
    );

    // writeback; destination PC is reported but not stored
    assign wb_en   = advance && ex_res.dest_written && ex_res.dest_reg != aaeu_pkg::PC_REG;
    assign wb_addr = ex_res.dest_reg;

    always_comb
    begin
        flags_next      = advance ? ex_res.flags_nzcv : flags_reg;
        regs_valid_next = regs_valid_reg;
        byp_valid_next  = byp_valid_reg;
        if (wb_en)
        begin
            regs_valid_next = regs_valid_reg | ({{(RC-1){1'b0}}, 1'b1} << wb_addr);
            byp_valid_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            flags_reg        <= '0;
            regs_valid_reg   <= '0;
            byp_valid_reg    <= 1'b0;
        end
        else
        begin
            ex_valid_reg     <= ex_valid_next;
            result_valid_reg <= result_valid_next;
            flags_reg        <= flags_next;
            regs_valid_reg   <= regs_valid_next;
            byp_valid_reg    <= byp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ex_data_reg <= instr_data;
        end
        if (advance)
        begin
            result_data_reg <= ex_res;
        end
        if (wb_en)
        begin
            byp_idx_reg  <= wb_addr;
            byp_data_reg <= ex_res.write_value;
        end
    end

endmodule

`default_nettype wire

// ===== design/aaeu_checker.sv =====
`default_nettype none

module aaeu_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           instr_valid,
    input wire logic           instr_stall,
    input wire logic           result_valid,
    input wire logic           result_stall,
    input wire aaeu_pkg::out_t result_data
);

    logic       in_fire;
    logic       out_fire;
    logic [2:0] inflight_reg, inflight_next;
    logic [3:0] last_flags_reg;

    assign in_fire  = instr_valid && !instr_stall;
    assign out_fire = result_valid && !result_stall;

    always_comb
    begin
        inflight_next = inflight_reg + {2'b00, in_fire} - {2'b00, out_fire};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg   <= '0;
            last_flags_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
            if (out_fire)
            begin
                last_flags_reg <= result_data.flags_nzcv;
            end
        end
    end

    // stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_data))
        else $error("stalled result changed");

    // execute stage plus output register: never more than two in flight
    a_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 3'd2)
        else $error("too many transactions in flight");

    // a skipped instruction leaves the flags as the last result showed them
    a_flags_kept: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_data.executed |->
            result_data.flags_nzcv == last_flags_reg)
        else $error("flags changed by a skipped instruction");

    a_skip_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_data.executed |->
            !result_data.dest_written && result_data.dest_reg == '0 &&
            result_data.write_value == '0)
        else $error("skipped instruction reports a result");

    // with nothing ahead, the result passes the execute stage and the output register without waiting
    a_no_lost: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && inflight_reg == 3'd0 |-> ##2 result_valid)
        else $error("result did not appear");

endmodule

bind arm_alu_execute_unit_core aaeu_checker u_aaeu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .instr_valid  (instr_valid),
    .instr_stall  (instr_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
);

`default_nettype wire
